// ===== rtl/core/wsht_pkg.sv =====
// Package with request/result types and codes for the window stack hit test core.
`timescale 1ns / 1ps

package wsht_pkg;

  localparam int unsigned FieldCoordW = 12;
  localparam int unsigned WindowIdW   = 5;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_CLICK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_IGNORED = 2'd1,
    ST_ADDED   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    func_e                  func;
    logic [FieldCoordW-1:0] left_x;
    logic [FieldCoordW-1:0] bottom_y;
    logic [FieldCoordW-1:0] right_x;
    logic [FieldCoordW-1:0] top_y;
    logic [FieldCoordW-1:0] point_x;
    logic [FieldCoordW-1:0] point_y;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [WindowIdW-1:0] window_id;
  } rsp_t;

endpackage

// ===== rtl/core/wsht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wsht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/window_stack_hit_test_core.sv =====
// Top level: z-ordered window stack with hit test and move-to-front.
//
// Usage: present a request on req_i and raise start_i; the request is taken
// at a rising edge where start_i is high and busy_o is low. Each request
// gives exactly one result on result_o, flagged by result_valid_o for a
// single cycle; the receiver takes it at the end of that cycle and cannot
// hold it off.
// An add writes the new rectangle into the stack memory at once and shows
// its result in the cycle after acceptance; busy_o stays low, so adds can
// follow back to back. A refused add (stack full) behaves the same way.
// A click walks the stack memory from the top down, with a read state and then
// a compare state per entry, through the one registered read port.
// On a hit below the top, every entry above the hit moves down one slot, each
// read and then written back; a last step writes the hit on top.
// busy_o stays high while entries are examined and, when a hit moves, while
// the entries above it shift and the hit goes on top; the result shows as
// busy_o falls, in the first cycle with busy_o low. A click on an empty
// stack never raises busy_o and answers in the cycle after acceptance.
// Reset empties the stack (count to zero); memory contents are not cleared.

module window_stack_hit_test_core
  import wsht_pkg::*;
#(
  parameter int unsigned MAX_WINDOWS = 16,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t result_o
);

  localparam int unsigned IdxW = $clog2(MAX_WINDOWS);
  localparam int unsigned CntW = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned EW   = 4 * CW + CntW;

  // Entry layout: {left, bottom, right, top, id}
  localparam int unsigned IdLo     = 0;
  localparam int unsigned TopLo    = CntW;
  localparam int unsigned RightLo  = CntW + CW;
  localparam int unsigned BottomLo = CntW + 2 * CW;
  localparam int unsigned LeftLo   = CntW + 3 * CW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SRD,
    S_SWR,
    S_TOP
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [EW-1:0]   hit_q, hit_d;
  logic [CW-1:0]   px_q, px_d;
  logic [CW-1:0]   py_q, py_d;
  logic            rsp_valid_q, rsp_valid_d;
  rsp_t            rsp_q, rsp_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [EW-1:0]   ram_rdata;

  logic            accept;
  logic [IdxW-1:0] last_idx;
  logic            enclosed;
  logic [CW-1:0]   e_left, e_bottom, e_right, e_top;

  wsht_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_WINDOWS)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign accept   = start_i && (state_q == S_IDLE);
  assign last_idx = IdxW'(count_q - 1'b1);

  assign e_left   = ram_rdata[LeftLo +: CW];
  assign e_bottom = ram_rdata[BottomLo +: CW];
  assign e_right  = ram_rdata[RightLo +: CW];
  assign e_top    = ram_rdata[TopLo +: CW];
  assign enclosed = (e_left <= px_q) && (px_q <= e_right) &&
                    (e_bottom <= py_q) && (py_q <= e_top);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    j_d         = j_q;
    hit_d       = hit_q;
    px_d        = px_q;
    py_d        = py_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = IdxW'(count_q);
    ram_wdata   = {CW'(req_i.left_x), CW'(req_i.bottom_y), CW'(req_i.right_x),
                   CW'(req_i.top_y), CntW'(count_q + 1'b1)};
    ram_raddr   = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          px_d = CW'(req_i.point_x);
          py_d = CW'(req_i.point_y);
          if (req_i.func == FUNC_ADD) begin
            rsp_valid_d = 1'b1;
            if (count_q == CntW'(MAX_WINDOWS)) begin
              rsp_d = '{status: ST_FULL, window_id: '0};
            end else begin
              ram_we  = 1'b1;
              count_d = CntW'(count_q + 1'b1);
              rsp_d   = '{status: ST_ADDED, window_id: WindowIdW'(count_q + 1'b1)};
            end
          end else if (count_q == '0) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: ST_IGNORED, window_id: '0};
          end else begin
            idx_d   = last_idx;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        ram_raddr = idx_q;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (enclosed) begin
          hit_d = ram_rdata;
          if (idx_q == last_idx) begin
            // Already on top: nothing to move
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: ST_HIT,
                            window_id: WindowIdW'(ram_rdata[IdLo +: CntW])};
            state_d     = S_IDLE;
          end else begin
            j_d     = idx_q;
            state_d = S_SRD;
          end
        end else if (idx_q == '0) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: ST_IGNORED, window_id: '0};
          state_d     = S_IDLE;
        end else begin
          idx_d   = IdxW'(idx_q - 1'b1);
          state_d = S_RD;
        end
      end
      S_SRD: begin
        ram_raddr = IdxW'(j_q + 1'b1);
        state_d   = S_SWR;
      end
      S_SWR: begin
        // Shift the entry above down into slot j
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = ram_rdata;
        j_d       = IdxW'(j_q + 1'b1);
        state_d   = (IdxW'(j_q + 1'b1) == last_idx) ? S_TOP : S_SRD;
      end
      S_TOP: begin
        ram_we      = 1'b1;
        ram_waddr   = last_idx;
        ram_wdata   = hit_q;
        rsp_valid_d = 1'b1;
        rsp_d       = '{status: ST_HIT, window_id: WindowIdW'(hit_q[IdLo +: CntW])};
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    j_q   <= j_d;
    hit_q <= hit_d;
    px_q  <= px_d;
    py_q  <= py_d;
    rsp_q <= rsp_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rsp_valid_q;
  assign result_o       = rsp_q;

endmodule

// ===== rtl/core/wsht_chk.sv =====
// Port-level checker for the window stack hit test core, with its bind.
`timescale 1ns / 1ps

module wsht_chk
  import wsht_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic result_valid_o,
  input rsp_t result_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  // An add always answers in the next cycle
  a_add_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.func == FUNC_ADD) |=> result_valid_o)
    else $error("add request not answered in next cycle");

  // Added or full results come only from an add request
  a_add_status_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == ST_ADDED || result_o.status == ST_FULL)
    |-> $past(accept && (req_i.func == FUNC_ADD)))
    else $error("add status without add request");

  // A click keeps the core busy or answers at once
  a_click_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.func == FUNC_CLICK) |=> busy_o || result_valid_o)
    else $error("click request dropped");

  // A result closes the work, so the core is free again
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result shown while busy");

  // No identifier on ignored or refused requests; real ones on hits and adds
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((result_o.window_id == '0) ==
      (result_o.status == ST_IGNORED || result_o.status == ST_FULL)))
    else $error("window id does not match status");

endmodule

bind window_stack_hit_test_core wsht_chk u_wsht_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .req_i         (req_i),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
